>>> sv/plic_pkg.sv
`timescale 1ns / 1ps
package plic_pkg;
  localparam int unsigned MaxExtent = 256;
  localparam int unsigned ExtW = 9;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LinW = 26;
  localparam int unsigned IdxW = 24;
  localparam int unsigned OutW = 8;
  localparam int unsigned CfgIdxW = 2;
  // wrap quotient width: |coord| < 2^16 and extent >= 1
  localparam int unsigned QW = 17;
  // lin index digit width for reverse division
  localparam int unsigned LQW = 25;
  // stages of the pipelined divider, four quotient bits per stage (two in the last)
  localparam int unsigned DivStages = (LinW + 3) / 4;

  localparam logic [CfgIdxW-1:0] RegSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSizeY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSizeZ = 2'd2;

  typedef enum logic {OpToIndex = 1'b0, OpToCoord = 1'b1} op_t;

  typedef struct packed {
    logic [ExtW-1:0] ex;
    logic [ExtW-1:0] ey;
    logic [ExtW-1:0] ez;
  } ext_t;

  // clamp a raw extent register into 1..MaxExtent
  function automatic logic [ExtW-1:0] clamp_ext(input logic [ExtW-1:0] r);
    logic [ExtW-1:0] v;
    begin
      v = r;
      if (r == '0) v = ExtW'(1);
      else if ({23'd0, r} > 32'(MaxExtent)) v = ExtW'(MaxExtent);
      return v;
    end
  endfunction
endpackage

>>> sv/plic_divstep.sv
`timescale 1ns / 1ps
// one restoring-division stage: brings down bits_i dividend bits (at most four) at once
// (fixed structure per instance; each divider lane has its own instances)
module plic_divstep (
  input  logic [25:0] rem_i,
  input  logic [25:0] num_i,
  input  logic [8:0]  den_i,
  input  logic [3:0]  bits_i,
  output logic [25:0] rem_o,
  output logic [25:0] num_o,
  output logic [3:0]  qbits_o
);
  logic [26:0] r;
  logic [25:0] n;
  logic [3:0]  q;
  // shift-subtract over bits_i bits, at most four
  always_comb begin
    r = {1'b0, rem_i};
    n = num_i;
    q = '0;
    for (int k = 0; k < 4; k++) begin
      if (k < int'(bits_i)) begin
        r = {r[25:0], n[25]};
        n = {n[24:0], 1'b0};
        q = {q[2:0], 1'b0};
        if (r >= {18'd0, den_i}) begin
          r = r - {18'd0, den_i};
          q[0] = 1'b1;
        end
      end
    end
    rem_o = r[25:0];
    num_o = n;
    qbits_o = q;
  end
endmodule

>>> sv/plic_div.sv
`timescale 1ns / 1ps
// pipelined divider: 26-bit unsigned by 9-bit divisor, 4 bits per stage, 2 in the last
module plic_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [plic_pkg::LinW-1:0] num_i,
  input  logic [8:0]                den_i,
  output logic [plic_pkg::LinW-1:0] quo_o,
  output logic [8:0]                rem_o
);
  logic [25:0] rem_r [plic_pkg::DivStages+1];
  logic [25:0] num_r [plic_pkg::DivStages+1];
  logic [plic_pkg::LinW-1:0] quo_r [plic_pkg::DivStages+1];
  logic [8:0] den_r [plic_pkg::DivStages+1];

  assign rem_r[0] = '0;
  assign num_r[0] = num_i;
  assign quo_r[0] = '0;
  assign den_r[0] = den_i;

  for (genvar s = 0; s < plic_pkg::DivStages; s++) begin : g_st
    localparam int unsigned NB =
      ((plic_pkg::LinW - 4*s) < 4) ? (plic_pkg::LinW - 4*s) : 4;
    logic [25:0] rem_nxt, num_nxt;
    logic [3:0]  q;
    logic [25:0] rem_q, num_q;
    logic [plic_pkg::LinW-1:0] quo_q;
    logic [8:0] den_q;
    plic_divstep u_st (
      .rem_i(rem_r[s]), .num_i(num_r[s]), .den_i(den_r[s]),
      .bits_i(4'(NB)), .rem_o(rem_nxt), .num_o(num_nxt), .qbits_o(q)
    );
    // stage register
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_nxt;
        num_q <= num_nxt;
        quo_q <= (quo_r[s] << NB) | plic_pkg::LinW'(q);
        den_q <= den_r[s];
      end
    end
    assign rem_r[s+1] = rem_q;
    assign num_r[s+1] = num_q;
    assign quo_r[s+1] = quo_q;
    assign den_r[s+1] = den_q;
  end

  assign quo_o = quo_r[plic_pkg::DivStages];
  assign rem_o = rem_r[plic_pkg::DivStages][8:0];
endmodule

>>> sv/periodic_lattice_index_converter_top.sv
`timescale 1ns / 1ps
// Periodic lattice index converter.
// Input channel: an item (in_operation, coordinates or linear index) is
// taken at a clock edge where start is high and busy is low. busy is
// tied low: the block takes one item every cycle.
// Forward mode wraps signed coordinates by true modulo into the extents
// and gives z + size_z*(y + size_y*x); reverse mode splits the index
// into x, y, z, flagging an index below zero or at or above the volume.
// Results appear on the out_ ports for one cycle with out_valid high,
// one result per cycle at full rate. The pipeline runs through the
// input register, the volume and range-check stage, two chained
// pipelined dividers (seven stages each, four quotient bits per stage,
// two in the last), the final multiply-add stage and the output register.
// Extents are written through the cfg_ port (index 0..2 for x, y, z);
// a write to any other index is dropped. cfg_ready is always high.
// Reset clears all valid bits and sets each extent to 1.
// The receiver cannot stall; results must be taken when shown.
module periodic_lattice_index_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_coord_x,
  input  logic [15:0] in_coord_y,
  input  logic [15:0] in_coord_z,
  input  logic [25:0] in_linear_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  output logic [23:0] out_index_out,
  output logic [7:0]  out_out_x,
  output logic [7:0]  out_out_y,
  output logic [7:0]  out_out_z,
  output logic        out_out_of_range
);
  localparam int unsigned L1 = plic_pkg::DivStages;  // stages of each divider

  logic [8:0] sx_r, sy_r, sz_r;
  plic_pkg::ext_t ext;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= 9'd1; sy_r <= 9'd1; sz_r <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        plic_pkg::RegSizeX: sx_r <= cfg_data;
        plic_pkg::RegSizeY: sy_r <= cfg_data;
        plic_pkg::RegSizeZ: sz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ext.ex = plic_pkg::clamp_ext(sx_r);
  assign ext.ey = plic_pkg::clamp_ext(sy_r);
  assign ext.ez = plic_pkg::clamp_ext(sz_r);

  // stage 0: register input, absolute values, volume part
  logic       v0_r, op0_r, nx0_r, ny0_r, nz0_r;
  logic [16:0] ax0_r, ay0_r, az0_r;
  logic [25:0] li0_r;
  logic [17:0] vxy0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
  end
  always_ff @(posedge clk) begin
    op0_r <= in_operation;
    nx0_r <= in_coord_x[15]; ny0_r <= in_coord_y[15]; nz0_r <= in_coord_z[15];
    ax0_r <= in_coord_x[15] ? 17'(-$signed({in_coord_x[15], in_coord_x}))
                            : {1'b0, in_coord_x};
    ay0_r <= in_coord_y[15] ? 17'(-$signed({in_coord_y[15], in_coord_y}))
                            : {1'b0, in_coord_y};
    az0_r <= in_coord_z[15] ? 17'(-$signed({in_coord_z[15], in_coord_z}))
                            : {1'b0, in_coord_z};
    li0_r <= in_linear_index;
    vxy0_r <= ext.ex * ext.ey;
  end

  // stage 1: volume and range check
  logic v1_r, op1_r, oor1_r, nx1_r, ny1_r, nz1_r;
  logic [16:0] ax1_r, ay1_r, az1_r;
  logic [25:0] li1_r;
  logic [26:0] vol;
  assign vol = vxy0_r * ext.ez;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    op1_r <= op0_r;
    oor1_r <= li0_r[25] || ({1'b0, li0_r} >= vol);
    nx1_r <= nx0_r; ny1_r <= ny0_r; nz1_r <= nz0_r;
    ax1_r <= ax0_r; ay1_r <= ay0_r; az1_r <= az0_r;
    li1_r <= li0_r[25] ? '0 : li0_r;
  end

  // dividers: reverse li/ez then rest/ey; forward three wraps
  logic [25:0] q1;
  logic [8:0]  r1;
  plic_div u_dli (
    .clk(clk), .en(1'b1), .num_i(li1_r), .den_i(ext.ez), .quo_o(q1), .rem_o(r1)
  );
  logic [25:0] qx, qy, qz, q2;
  logic [8:0]  rx, ry, rz, r2;
  plic_div u_dx (
    .clk(clk), .en(1'b1), .num_i({9'd0, ax1_r}), .den_i(ext.ex), .quo_o(qx),
    .rem_o(rx));
  plic_div u_dy (
    .clk(clk), .en(1'b1), .num_i({9'd0, ay1_r}), .den_i(ext.ey), .quo_o(qy),
    .rem_o(ry));
  plic_div u_dz (
    .clk(clk), .en(1'b1), .num_i({9'd0, az1_r}), .den_i(ext.ez), .quo_o(qz),
    .rem_o(rz));

  // sideband delay lines through the dividers
  logic [L1-1:0] vd_r, opd_r, oord_r, nxd_r, nyd_r, nzd_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= '0;
    else vd_r <= {vd_r[L1-2:0], v1_r};
  end
  always_ff @(posedge clk) begin
    opd_r <= {opd_r[L1-2:0], op1_r};
    oord_r <= {oord_r[L1-2:0], oor1_r};
    nxd_r <= {nxd_r[L1-2:0], nx1_r};
    nyd_r <= {nyd_r[L1-2:0], ny1_r};
    nzd_r <= {nzd_r[L1-2:0], nz1_r};
  end
  // true modulo: a negative coordinate wraps from the far side
  logic [8:0] fx, fy, fz;
  assign fx = (nxd_r[L1-1] && rx != '0) ? ext.ex - rx : rx;
  assign fy = (nyd_r[L1-1] && ry != '0) ? ext.ey - ry : ry;
  assign fz = (nzd_r[L1-1] && rz != '0) ? ext.ez - rz : rz;

  // stage after first divider: forward y + ey*x, reverse second divide
  logic v3_r, op3_r, oor3_r;
  logic [16:0] t3_r;
  logic [8:0]  wz3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= vd_r[L1-1];
  end
  always_ff @(posedge clk) begin
    op3_r <= opd_r[L1-1];
    oor3_r <= oord_r[L1-1];
    t3_r <= 17'(fy) + 17'(ext.ey) * 17'(fx);
    wz3_r <= fz;
  end
  plic_div u_dr (
    .clk(clk), .en(1'b1), .num_i(q1), .den_i(ext.ey), .quo_o(q2), .rem_o(r2)
  );
  logic [L1-1:0] v4d_r, op4d_r, oor4d_r;
  logic [16:0] t4_r [L1-1];
  logic [8:0]  z4_r [L1];
  logic [8:0]  rz4_r [L1-1];
  always_ff @(posedge clk) begin
    if (!rst_n) v4d_r <= '0;
    else v4d_r <= {v4d_r[L1-2:0], vd_r[L1-1]};
  end
  always_ff @(posedge clk) begin
    op4d_r <= {op4d_r[L1-2:0], opd_r[L1-1]};
    oor4d_r <= {oor4d_r[L1-2:0], oord_r[L1-1]};
    z4_r[0] <= r1;
    t4_r[0] <= t3_r; rz4_r[0] <= wz3_r;
    for (int i = 1; i < L1; i++) begin
      z4_r[i] <= z4_r[i-1];
    end
    for (int i = 1; i < L1 - 1; i++) begin
      t4_r[i] <= t4_r[i-1]; rz4_r[i] <= rz4_r[i-1];
    end
  end
  // t3 is registered after r1 appears; align via offset taps
  logic [16:0] tf;
  logic [8:0]  zf;
  assign tf = t4_r[L1-2];
  assign zf = rz4_r[L1-2];

  // final multiply-add stage
  logic v5_r, op5_r, oor5_r;
  logic [24:0] idx5_r;
  logic [8:0] ox5_r, oy5_r, oz5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4d_r[L1-1];
  end
  always_ff @(posedge clk) begin
    op5_r <= op4d_r[L1-1];
    oor5_r <= oor4d_r[L1-1];
    idx5_r <= 25'(zf) + 25'(ext.ez) * 25'(tf);
    ox5_r <= q2[8:0]; oy5_r <= r2; oz5_r <= z4_r[L1-1];
  end

  // output register
  logic ov_r, oor_r;
  logic [23:0] oi_r;
  logic [7:0] ox_r, oy_r, oz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (op5_r == plic_pkg::OpToIndex) begin
      oi_r <= idx5_r[23:0];
      ox_r <= '0; oy_r <= '0; oz_r <= '0; oor_r <= 1'b0;
    end else begin
      oi_r <= '0;
      oor_r <= oor5_r;
      ox_r <= oor5_r ? '0 : ox5_r[7:0];
      oy_r <= oor5_r ? '0 : oy5_r[7:0];
      oz_r <= oor5_r ? '0 : oz5_r[7:0];
    end
  end

  assign out_valid = ov_r;
  assign out_index_out = oi_r;
  assign out_out_x = ox_r;
  assign out_out_y = oy_r;
  assign out_out_z = oz_r;
  assign out_out_of_range = oor_r;
endmodule

>>> sv/plic_checker.sv
`timescale 1ns / 1ps
module plic_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        start,
  input logic        out_valid,
  input logic [23:0] out_index_out,
  input logic [7:0]  out_out_x,
  input logic        out_out_of_range
);
  // no result out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");
  // the block never refuses an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  // an out of range result carries no coordinates
  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_out_x == '0 && out_index_out == '0)
    else $error("out of range with data");
  // no result without an earlier item
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(start, 18) || !$past(rst_n, 18))
    else $error("result without item");
endmodule

bind periodic_lattice_index_converter_top plic_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .start(start), .out_valid(out_valid),
  .out_index_out(out_index_out), .out_out_x(out_out_x),
  .out_out_of_range(out_out_of_range)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  // one expected conversion result
  typedef struct {
    logic [23:0] index_out;
    logic [7:0]  ox;
    logic [7:0]  oy;
    logic [7:0]  oz;
    logic        oor;
  } site_res_t;

  // scoreboard: predicts conversions from the current extents
  class lattice_sb;
    logic [8:0] reg_x, reg_y, reg_z;
    site_res_t  pending_q[$];
    int unsigned n_fwd, n_rev, n_oor, n_checked;
    int unsigned err_cnt;

    task report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      err_cnt++;
    endtask

    function void reset_regs();
      reg_x = 9'd1;
      reg_y = 9'd1;
      reg_z = 9'd1;
    endfunction

    function longint eff_ext(input logic [8:0] r);
      if (r == 9'd0) return 1;
      if (r > 9'(plic_pkg::MaxExtent)) return plic_pkg::MaxExtent;
      return r;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [8:0] val);
      if (idx == plic_pkg::RegSizeX) reg_x = val;
      else if (idx == plic_pkg::RegSizeY) reg_y = val;
      else if (idx == plic_pkg::RegSizeZ) reg_z = val;
    endfunction

    function void note_item(input plic_pkg::op_t op, input logic signed [15:0] cx,
                            input logic signed [15:0] cy,
                            input logic signed [15:0] cz,
                            input logic signed [25:0] li);
      longint ex, ey, ez, wx, wy, wz, lv, vol;
      site_res_t r;
      ex = eff_ext(reg_x);
      ey = eff_ext(reg_y);
      ez = eff_ext(reg_z);
      r = '{default: '0};
      if (op == plic_pkg::OpToIndex) begin
        wx = longint'(cx) % ex;
        if (wx < 0) wx += ex;
        wy = longint'(cy) % ey;
        if (wy < 0) wy += ey;
        wz = longint'(cz) % ez;
        if (wz < 0) wz += ez;
        r.index_out = 24'(wz + ez * (wy + ey * wx));
        n_fwd++;
      end else begin
        lv = longint'(li);
        vol = ex * ey * ez;
        n_rev++;
        if (lv < 0 || lv >= vol) begin
          r.oor = 1'b1;
          n_oor++;
        end else begin
          r.oz = 8'(lv % ez);
          r.oy = 8'((lv / ez) % ey);
          r.ox = 8'((lv / ez) / ey);
        end
      end
      pending_q.push_back(r);
    endfunction

    task check_result(input site_res_t got);
      site_res_t e;
      if (pending_q.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending_q.pop_front();
      n_checked++;
      if (got.index_out !== e.index_out)
        report($sformatf("index_out got %0h exp %0h", got.index_out, e.index_out));
      if (got.ox !== e.ox) report($sformatf("out_x got %0h exp %0h", got.ox, e.ox));
      if (got.oy !== e.oy) report($sformatf("out_y got %0h exp %0h", got.oy, e.oy));
      if (got.oz !== e.oz) report($sformatf("out_z got %0h exp %0h", got.oz, e.oz));
      if (got.oor !== e.oor)
        report($sformatf("out_of_range got %0b exp %0b", got.oor, e.oor));
    endtask
  endclass

  logic clk, rst_n, start, busy;
  logic in_operation;
  logic [15:0] in_coord_x, in_coord_y, in_coord_z;
  logic [25:0] in_linear_index;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  logic out_valid, out_out_of_range;
  logic [23:0] out_index_out;
  logic [7:0] out_out_x, out_out_y, out_out_z;

  lattice_sb sb = new();
  int unsigned quiet_cycles = 0;
  bit calm_mode = 0;

  periodic_lattice_index_converter_top u_top (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_index_out, out_out_x, out_out_y, out_out_z,
                        out_out_of_range});
  end

  // watchdog on cycles with no accepted item, config write or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("watchdog expired");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_cfg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_extents(input logic [8:0] x, input logic [8:0] y,
                             input logic [8:0] z);
    write_cfg(plic_pkg::RegSizeX, x);
    write_cfg(plic_pkg::RegSizeY, y);
    write_cfg(plic_pkg::RegSizeZ, z);
  endtask

  // send one item, with random gaps before it unless calm_mode is set
  task automatic send_item(input plic_pkg::op_t op, input logic [15:0] cx,
                           input logic [15:0] cy, input logic [15:0] cz,
                           input logic [25:0] li);
    while (!calm_mode && $urandom_range(99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_coord_x <= cx;
    in_coord_y <= cy;
    in_coord_z <= cz;
    in_linear_index <= li;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(op, cx, cy, cz, li);
  endtask

  // wait for all results plus the pipeline drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random item biased toward interesting ranges
  task automatic rand_item();
    plic_pkg::op_t op;
    logic [25:0] li;
    longint vol;
    op = plic_pkg::op_t'($urandom_range(1));
    vol = sb.eff_ext(sb.reg_x) * sb.eff_ext(sb.reg_y) * sb.eff_ext(sb.reg_z);
    case ($urandom_range(3))
      0: li = 26'($urandom);
      1: li = 26'(vol - 2 + $urandom_range(3));
      default: li = 26'(longint'($urandom) % vol);
    endcase
    send_item(op, 16'($urandom), 16'($urandom),
              ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(600)) - 16'd300),
              li);
  endtask

  initial begin
    logic [8:0] extents[8];
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = plic_pkg::OpToIndex;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    in_linear_index = '0;
    cfg_valid = 1'b0;
    cfg_index = plic_pkg::RegSizeX;
    cfg_data = '0;
    sb.reset_regs();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset extents, then extremes and special cases
    send_item(plic_pkg::OpToIndex, 16'h7fff, 16'h8000, 16'hffff, '0);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd0);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd1);
    drain();
    set_extents(9'd256, 9'd256, 9'd256);
    send_item(plic_pkg::OpToIndex, 16'h8000, 16'h8000, 16'h8000, '0);
    send_item(plic_pkg::OpToIndex, 16'h7fff, 16'h7fff, 16'h7fff, '0);
    send_item(plic_pkg::OpToIndex, 16'hffff, 16'h0000, 16'h00ff, 26'h3ffffff);
    send_item(plic_pkg::OpToCoord, 16'hffff, 16'hffff, 16'hffff, 26'hffffff);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'h1000000);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'h1ffffff);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'h2000000);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'h3ffffff);
    drain();
    // zero and oversized registers
    set_extents(9'd0, 9'd511, 9'd257);
    send_item(plic_pkg::OpToIndex, 16'h1234, 16'hfedc, 16'hffff, '0);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd65535);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd65536);
    drain();
    set_extents(9'd3, 9'd5, 9'd7);
    send_item(plic_pkg::OpToIndex, 16'hfffd, 16'hfffb, 16'hfff9, '0);
    send_item(plic_pkg::OpToIndex, 16'hffff, 16'hffff, 16'hffff, '0);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd104);
    send_item(plic_pkg::OpToCoord, '0, '0, '0, 26'd105);
    drain();
    // config index beyond the register list is dropped
    write_cfg(2'd3, 9'd17);
    send_item(plic_pkg::OpToIndex, 16'd10, 16'd10, 16'd10, '0);
    drain();

    // random phases over varied extents
    extents = '{9'd1, 9'd2, 9'd7, 9'd100, 9'd255, 9'd256, 9'd0, 9'd300};
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 12) set_extents(9'd256, 9'd256, 9'd256);
      else if (ph % 3 == 0)
        set_extents(extents[$urandom_range(7)], extents[$urandom_range(7)],
                    extents[$urandom_range(7)]);
      else
        set_extents(9'($urandom), 9'($urandom), 9'($urandom));
      calm_mode = (ph == 4);
      for (int k = 0; k < 50; k++) rand_item();
      calm_mode = 0;
      drain();
    end

    $display("covered %0d forward and %0d reverse conversions, %0d out of range",
             sb.n_fwd, sb.n_rev, sb.n_oor);
    $display("checked %0d results over 13 extent settings", sb.n_checked);
    if (sb.err_cnt == 0 && sb.pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
